>>> src/bse_pkg.sv
package bse_pkg;

   // Storage sizes
   localparam int CTRL_DEPTH  = 256;
   localparam int CTRL_ADDR_W = 8;
   localparam int KNOT_DEPTH  = 32;
   localparam int KNOT_IDX_W  = 5;
   localparam int ROW_DEPTH   = 32;

   // Number formats
   localparam int VAL_W   = 17;
   localparam int BASIS_W = 18;
   localparam int COORD_W = 32;

   localparam logic [VAL_W-1:0]   ONE_Q16   = 17'h10000;
   localparam logic [BASIS_W-1:0] BASIS_MAX = 18'h3FFFF;

   // Stream payload widths
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 96;

   // Divider operand widths
   localparam int DIV_NUM_W = 35;
   localparam int DIV_DEN_W = 17;
   localparam int DIV_CNT_W = 6;

   typedef enum logic [1:0] {
      CMD_LOAD_POINT  = 2'd0,
      CMD_LOAD_U_KNOT = 2'd1,
      CMD_LOAD_V_KNOT = 2'd2,
      CMD_EVAL        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_U_LAST   = 2'd0,
      CSR_V_LAST   = 2'd1,
      CSR_U_DEGREE = 2'd2,
      CSR_V_DEGREE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

>>> src/bse_div.sv
module bse_div import bse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // One restoring step: bring down the next dividend bit and try the divisor.
   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         rem_in  = '0;
         den_in  = req.den;
         quo_in  = req.num;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

>>> src/bspline_surface_evaluator.sv
// Channel   Direction  Transaction
// req_*     in         command in tuser; slots, knot, point and parameters in tdata
// rsp_*     out        evaluated point x, y, z in tdata
// csr_*     in         register write: index and data
//
// Loads are stored as they are accepted. An evaluation runs both basis recursions
// then the weighted sum over all control points on one shared multiplier and one
// bit-serial divider. Per axis the degree zero row comes first; each recursion
// term then fetches its knots and lower basis values and forms two quotients, each
// a multiply, a divider start and a wait, and a quotient whose divisor or product
// is zero is skipped. The sum reads each control point and its weight and
// accumulates x, y and z. req_tready is low during an evaluation. The result waits
// in an output register while further loads are taken. Reset is synchronous and
// restores the register defaults; the stores need no clearing.
module bspline_surface_evaluator import bse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] u_slot, [7:4] v_slot, [12:8] knot_slot, [29:13] knot_value,
   // [61:30] load_x, [93:62] load_y, [125:94] load_z, [142:126] eval_u,
   // [159:143] eval_v
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] point_x, [63:32] point_y, [95:64] point_z
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [3:0]            csr_data
);

   typedef enum logic [14:0] {
      ST_IDLE    = 15'h0001,
      ST_INIT    = 15'h0002,
      ST_FETCH   = 15'h0004,
      ST_MUL     = 15'h0008,
      ST_DIVGO   = 15'h0010,
      ST_DIVWAIT = 15'h0020,
      ST_WRBACK  = 15'h0040,
      ST_MACRD   = 15'h0080,
      ST_MACW    = 15'h0100,
      ST_MACR    = 15'h0200,
      ST_MX      = 15'h0400,
      ST_MY      = 15'h0800,
      ST_MZ      = 15'h1000,
      ST_MN      = 15'h2000,
      ST_OUT     = 15'h4000
   } state_type;

   function automatic logic [COORD_W-1:0] round_sat(input logic signed [61:0] a);
      logic signed [61:0] s;
      logic signed [45:0] r;
      begin
         s = a + 62'sd32768;
         r = s[61:16];
         if (r > 46'sd2147483647)
            round_sat = 32'h7FFFFFFF;
         else if (r < -46'sd2147483648)
            round_sat = 32'h80000000;
         else
            round_sat = r[31:0];
      end
   endfunction

   // Configuration registers
   logic [3:0] ulast_ff, vlast_ff;
   logic [2:0] udeg_ff, vdeg_ff;

   // Sequencer registers
   state_type            state_ff, state_in;
   logic [2:0]           ph_ff, ph_in;
   logic                 axis_ff, axis_in;
   logic [4:0]           i_ff, i_in;
   logic [2:0]           d_ff, d_in;
   logic                 term_ff, term_in;
   logic signed [37:0]   acc_ff, acc_in;
   logic                 sign_ff, sign_in;
   logic [VAL_W-1:0]     ti_ff, ti_in, ti1_ff, ti1_in, tid_ff, tid_in, tid1_ff, tid1_in;
   logic [BASIS_W-1:0]   ni_ff, ni_in, ni1_ff, ni1_in;
   logic [VAL_W-1:0]     eu_ff, eu_in, ev_ff, ev_in;
   logic [3:0]           mi_ff, mi_in, mj_ff, mj_in;
   logic [19:0]          w_ff, w_in;
   logic signed [54:0]   prod_ff, prod_in;
   logic signed [61:0]   ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Stores and their registered read ports
   logic [COORD_W-1:0] ctrl_x_mem [CTRL_DEPTH];
   logic [COORD_W-1:0] ctrl_y_mem [CTRL_DEPTH];
   logic [COORD_W-1:0] ctrl_z_mem [CTRL_DEPTH];
   logic [VAL_W-1:0]   u_knot_mem [KNOT_DEPTH];
   logic [VAL_W-1:0]   v_knot_mem [KNOT_DEPTH];
   logic [BASIS_W-1:0] u_row_mem  [ROW_DEPTH];
   logic [BASIS_W-1:0] v_row_mem  [ROW_DEPTH];
   logic [COORD_W-1:0] cx_q_ff, cy_q_ff, cz_q_ff;
   logic [VAL_W-1:0]   ku_q_ff, kv_q_ff;
   logic               kzero_ff, kone_ff;
   logic [BASIS_W-1:0] uq_ff, vq_ff;

   // Combinational helpers
   cmd_type               cmd;
   logic                  req_acc;
   logic [3:0]            last_c;
   logic [2:0]            deg_c;
   logic [VAL_W-1:0]      x_c;
   logic [4:0]            top_c;
   logic [4:0]            kaddr;
   logic [KNOT_IDX_W-1:0] kidx;
   logic [VAL_W-1:0]      tval;
   logic [BASIS_W-1:0]    rq;
   logic [4:0]            ridx_u, ridx_v;
   logic [CTRL_ADDR_W-1:0] caddr;
   logic [CTRL_ADDR_W-1:0] paddr;
   logic signed [32:0]    mul_a;
   logic signed [21:0]    mul_b;
   logic                  mul_en;
   logic signed [17:0]    diff1, diff2, den1, den2, den_c;
   logic [54:0]           prod_abs;
   logic [17:0]           den_abs;
   logic                  skip;
   logic signed [37:0]    qsigned;
   logic [BASIS_W-1:0]    acc_sat;
   logic                  on_c;
   logic                  row_we;
   logic [BASIS_W-1:0]    row_wdata;
   logic                  fin_axis;
   logic [54:0]           wsum;
   logic [VAL_W-1:0]      knot_clamped, eu_clamped, ev_clamped;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   assign cmd        = cmd_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Values above one are taken as one.
   assign knot_clamped = (req_tdata[29:13] > ONE_Q16) ? ONE_Q16 : req_tdata[29:13];
   assign eu_clamped   = (req_tdata[142:126] > ONE_Q16) ? ONE_Q16 : req_tdata[142:126];
   assign ev_clamped   = (req_tdata[159:143] > ONE_Q16) ? ONE_Q16 : req_tdata[159:143];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ulast_ff <= 4'd3;
         vlast_ff <= 4'd3;
         udeg_ff  <= 3'd3;
         vdeg_ff  <= 3'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_U_LAST:   ulast_ff <= csr_data;
            CSR_V_LAST:   vlast_ff <= csr_data;
            CSR_U_DEGREE: udeg_ff  <= csr_data[2:0];
            CSR_V_DEGREE: vdeg_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Settings of the axis under work
   assign last_c = axis_ff ? vlast_ff : ulast_ff;
   assign deg_c  = axis_ff ? vdeg_ff : udeg_ff;
   assign x_c    = axis_ff ? ev_ff : eu_ff;
   assign top_c  = 5'(last_c) + 5'(deg_c);

   // Knot vector position requested this cycle
   always_comb begin
      case (state_ff)
         ST_INIT:  kaddr = (ph_ff == 3'd0) ? i_ff : i_ff + 5'd1;
         ST_FETCH: begin
            case (ph_ff)
               3'd0:    kaddr = i_ff;
               3'd1:    kaddr = i_ff + 5'd1;
               3'd2:    kaddr = i_ff + 5'(d_ff);
               default: kaddr = i_ff + 5'(d_ff) + 5'd1;
            endcase
         end
         default:  kaddr = i_ff;
      endcase
   end
   assign kidx = kaddr - 5'(deg_c);

   // Clamped knot vector: leading zeros, stored interior knots, trailing ones.
   assign tval = kzero_ff ? '0 : (kone_ff ? ONE_Q16 : (axis_ff ? kv_q_ff : ku_q_ff));

   // Basis row read addresses
   assign ridx_u = (state_ff == ST_MACRD) ? 5'(mi_ff) : ((ph_ff == 3'd0) ? i_ff : i_ff + 5'd1);
   assign ridx_v = (state_ff == ST_MACRD) ? 5'(mj_ff) : ((ph_ff == 3'd0) ? i_ff : i_ff + 5'd1);
   assign rq     = axis_ff ? vq_ff : uq_ff;
   assign caddr  = {mi_ff, mj_ff};

   // A control point is stored at u_slot * 16 + v_slot.
   assign paddr  = {req_tdata[3:0], req_tdata[7:4]};

   // Stores
   always_ff @(posedge clock) begin
      if (req_acc && cmd == CMD_LOAD_POINT) begin
         ctrl_x_mem[paddr] <= req_tdata[61:30];
         ctrl_y_mem[paddr] <= req_tdata[93:62];
         ctrl_z_mem[paddr] <= req_tdata[125:94];
      end
      cx_q_ff <= ctrl_x_mem[caddr];
      cy_q_ff <= ctrl_y_mem[caddr];
      cz_q_ff <= ctrl_z_mem[caddr];
   end

   always_ff @(posedge clock) begin
      if (req_acc && cmd == CMD_LOAD_U_KNOT)
         u_knot_mem[req_tdata[12:8]] <= knot_clamped;
      if (req_acc && cmd == CMD_LOAD_V_KNOT)
         v_knot_mem[req_tdata[12:8]] <= knot_clamped;
      ku_q_ff  <= u_knot_mem[kidx];
      kv_q_ff  <= v_knot_mem[kidx];
      kzero_ff <= kaddr < 5'(deg_c);
      kone_ff  <= kaddr > (5'(last_c) + 5'd1);
   end

   always_ff @(posedge clock) begin
      if (row_we && !axis_ff)
         u_row_mem[i_ff] <= row_wdata;
      if (row_we && axis_ff)
         v_row_mem[i_ff] <= row_wdata;
      uq_ff <= u_row_mem[ridx_u];
      vq_ff <= v_row_mem[ridx_v];
   end

   // Recursion terms and their divisors
   assign diff1 = $signed({1'b0, x_c}) - $signed({1'b0, ti_ff});
   assign diff2 = $signed({1'b0, tid1_ff}) - $signed({1'b0, x_c});
   assign den1  = $signed({1'b0, tid_ff}) - $signed({1'b0, ti_ff});
   assign den2  = $signed({1'b0, tid1_ff}) - $signed({1'b0, ti1_ff});
   assign den_c = term_ff ? den2 : den1;

   // Shared multiplier operands
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_MUL: begin
            mul_a = term_ff ? 33'(diff2) : 33'(diff1);
            mul_b = $signed({4'b0, (term_ff ? ni1_ff : ni_ff)});
         end
         ST_MACW: begin
            mul_a = $signed({15'b0, uq_ff});
            mul_b = $signed({4'b0, vq_ff});
         end
         ST_MX: begin
            mul_a = 33'($signed(cx_q_ff));
            mul_b = $signed({2'b0, w_ff});
         end
         ST_MY: begin
            mul_a = 33'($signed(cy_q_ff));
            mul_b = $signed({2'b0, w_ff});
         end
         ST_MZ: begin
            mul_a = 33'($signed(cz_q_ff));
            mul_b = $signed({2'b0, w_ff});
         end
         default: mul_en = 1'b0;
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // Divider operands as sign and magnitude; quotients truncate toward zero.
   assign prod_abs = prod_ff[54] ? 55'(-prod_ff) : 55'(prod_ff);
   assign den_abs  = den_c[17] ? 18'(-den_c) : 18'(den_c);
   assign skip     = (den_c == '0) || (prod_ff == '0);
   assign div_req.start = (state_ff == ST_DIVGO) && !skip;
   assign div_req.num   = prod_abs[DIV_NUM_W-1:0];
   assign div_req.den   = den_abs[DIV_DEN_W-1:0];
   assign qsigned = sign_ff ? -$signed({3'b0, div_rsp.quo}) : $signed({3'b0, div_rsp.quo});

   bse_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign acc_sat = (acc_ff < 0) ? '0 :
                    ((acc_ff > $signed({20'b0, BASIS_MAX})) ? BASIS_MAX : acc_ff[BASIS_W-1:0]);

   // Degree zero basis, with the last span closed at one
   assign on_c = ((ti_ff <= x_c) && (x_c < tval)) ||
                 ((x_c == ONE_Q16) && (tval == ONE_Q16) && (ti_ff < ONE_Q16));

   assign wsum = prod_ff + 55'sd32768;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      axis_in      = axis_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      sign_in      = sign_ff;
      ti_in        = ti_ff;
      ti1_in       = ti1_ff;
      tid_in       = tid_ff;
      tid1_in      = tid1_ff;
      ni_in        = ni_ff;
      ni1_in       = ni1_ff;
      eu_in        = eu_ff;
      ev_in        = ev_ff;
      mi_in        = mi_ff;
      mj_in        = mj_ff;
      w_in         = w_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      row_we       = 1'b0;
      row_wdata    = acc_sat;
      fin_axis     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && cmd == CMD_EVAL) begin
               eu_in    = eu_clamped;
               ev_in    = ev_clamped;
               axis_in  = 1'b0;
               i_in     = '0;
               ph_in    = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  ti_in = tval;
                  ph_in = 3'd2;
               end
               default: begin
                  row_we    = 1'b1;
                  row_wdata = on_c ? BASIS_W'(ONE_Q16) : '0;
                  ph_in     = '0;
                  if (i_ff == top_c) begin
                     if (deg_c == '0) begin
                        fin_axis = 1'b1;
                     end else begin
                        d_in     = 3'd1;
                        i_in     = '0;
                        state_in = ST_FETCH;
                     end
                  end else begin
                     i_in = i_ff + 5'd1;
                  end
               end
            endcase
         end
         ST_FETCH: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  ti_in = tval;
                  ni_in = rq;
                  ph_in = 3'd2;
               end
               3'd2: begin
                  ti1_in = tval;
                  ni1_in = rq;
                  ph_in  = 3'd3;
               end
               3'd3: begin
                  tid_in = tval;
                  ph_in  = 3'd4;
               end
               default: begin
                  tid1_in  = tval;
                  ph_in    = '0;
                  term_in  = 1'b0;
                  acc_in   = '0;
                  state_in = ST_MUL;
               end
            endcase
         end
         ST_MUL: state_in = ST_DIVGO;
         ST_DIVGO: begin
            sign_in = prod_ff[54] ^ den_c[17];
            if (skip) begin
               term_in  = 1'b1;
               state_in = term_ff ? ST_WRBACK : ST_MUL;
            end else begin
               state_in = ST_DIVWAIT;
            end
         end
         ST_DIVWAIT: begin
            if (div_rsp.done) begin
               acc_in   = acc_ff + qsigned;
               term_in  = 1'b1;
               state_in = term_ff ? ST_WRBACK : ST_MUL;
            end
         end
         ST_WRBACK: begin
            row_we   = 1'b1;
            state_in = ST_FETCH;
            if (i_ff == top_c - 5'(d_ff)) begin
               i_in = '0;
               if (d_ff == deg_c)
                  fin_axis = 1'b1;
               else
                  d_in = d_ff + 3'd1;
            end else begin
               i_in = i_ff + 5'd1;
            end
         end
         ST_MACRD: state_in = ST_MACW;
         ST_MACW:  state_in = ST_MACR;
         ST_MACR: begin
            w_in     = wsum[35:16];
            state_in = ST_MX;
         end
         ST_MX: state_in = ST_MY;
         ST_MY: begin
            ax_in    = ax_ff + 62'(prod_ff);
            state_in = ST_MZ;
         end
         ST_MZ: begin
            ay_in    = ay_ff + 62'(prod_ff);
            state_in = ST_MN;
         end
         ST_MN: begin
            az_in    = az_ff + 62'(prod_ff);
            state_in = ST_MACRD;
            if (mj_ff == vlast_ff) begin
               mj_in = '0;
               if (mi_ff == ulast_ff)
                  state_in = ST_OUT;
               else
                  mi_in = mi_ff + 4'd1;
            end else begin
               mj_in = mj_ff + 4'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {round_sat(az_ff), round_sat(ay_ff), round_sat(ax_ff)};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // End of one axis: start the v row, or go on to the weighted sum.
      if (fin_axis) begin
         if (!axis_ff) begin
            axis_in  = 1'b1;
            i_in     = '0;
            ph_in    = '0;
            state_in = ST_INIT;
         end else begin
            mi_in    = '0;
            mj_in    = '0;
            ax_in    = '0;
            ay_in    = '0;
            az_in    = '0;
            state_in = ST_MACRD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff     <= axis_in;
      i_ff        <= i_in;
      d_ff        <= d_in;
      term_ff     <= term_in;
      acc_ff      <= acc_in;
      sign_ff     <= sign_in;
      ti_ff       <= ti_in;
      ti1_ff      <= ti1_in;
      tid_ff      <= tid_in;
      tid1_ff     <= tid1_in;
      ni_ff       <= ni_in;
      ni1_ff      <= ni1_in;
      eu_ff       <= eu_in;
      ev_ff       <= ev_in;
      mi_ff       <= mi_in;
      mj_ff       <= mj_in;
      w_ff        <= w_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      rsp_data_ff <= rsp_data_in;
      if (mul_en)
         prod_ff <= prod_in;
   end

   // The divider is only started when it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // A finished division is only ever awaited in the wait state.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVWAIT))
      else $error("quotient arrived outside the wait state");

   // An evaluate transaction closes the input until it is finished.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_EVAL) |=> !req_tready)
      else $error("input still open after an evaluate transaction");

   // A new result only comes from the output state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

endmodule

>>> verif/bse_surface_checker.sv
module bse_surface_checker import bse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [3:0]            csr_data,
   output int                    mismatches,
   output int                    points_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef longint basis_row_type [40];
   typedef logic [VAL_W-1:0] knot_list_type [KNOT_DEPTH];

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } surface_point_type;

   // Shadow copy of the block's stores and registers.
   logic signed [COORD_W-1:0] shadow_x [CTRL_DEPTH];
   logic signed [COORD_W-1:0] shadow_y [CTRL_DEPTH];
   logic signed [COORD_W-1:0] shadow_z [CTRL_DEPTH];
   knot_list_type             shadow_u_knots;
   knot_list_type             shadow_v_knots;
   logic [3:0]                u_last, v_last;
   logic [2:0]                u_deg, v_deg;

   surface_point_type expected_points [$];

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Cox-de Boor recursion on the clamped knot vector, in Q2.16.
   function automatic basis_row_type basis_values(input longint u, input int last,
                                                 input int deg, input knot_list_type knots);
      longint        t [40];
      basis_row_type row;
      longint        acc, d1, d2;
      int            cnt;
      cnt = last + deg + 2;
      for (int i = 0; i < 40; i++) begin
         row[i] = 0;
         t[i] = 0;
      end
      for (int i = 0; i < cnt; i++) begin
         if (i < deg) t[i] = 0;
         else if (i > last + 1) t[i] = 65536;
         else t[i] = longint'(knots[(i - deg) & (KNOT_DEPTH - 1)]);
      end
      for (int i = 0; i <= last + deg; i++) begin
         row[i] = ((t[i] <= u && u < t[i+1]) ||
                   (u == 65536 && t[i+1] == 65536 && t[i] < 65536)) ? 65536 : 0;
      end
      for (int d = 1; d <= deg; d++) begin
         for (int i = 0; i <= last + deg - d; i++) begin
            acc = 0;
            d1 = t[i+d] - t[i];
            d2 = t[i+d+1] - t[i+1];
            if (d1 != 0) acc += ((u - t[i]) * row[i]) / d1;
            if (d2 != 0) acc += ((t[i+d+1] - u) * row[i+1]) / d2;
            if (acc < 0) acc = 0;
            if (acc > 262143) acc = 262143;
            row[i] = acc;
         end
      end
      return row;
   endfunction

   // Q.32 sum to Q16.16, halves rounded upwards, saturated.
   function automatic logic signed [COORD_W-1:0] round_coord(input longint acc);
      longint r;
      if (acc >= 0) r = (acc + 32768) / 65536;
      else r = -((-acc + 32767) / 65536);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[COORD_W-1:0];
   endfunction

   function automatic surface_point_type surface_point(input longint u_in, input longint v_in);
      basis_row_type     nu, nv;
      longint            u, v, w, ax, ay, az;
      int                addr;
      surface_point_type pt;
      u = (u_in > 65536) ? 65536 : u_in;
      v = (v_in > 65536) ? 65536 : v_in;
      nu = basis_values(u, int'(u_last), int'(u_deg), shadow_u_knots);
      nv = basis_values(v, int'(v_last), int'(v_deg), shadow_v_knots);
      ax = 0;
      ay = 0;
      az = 0;
      for (int i = 0; i <= int'(u_last); i++) begin
         for (int j = 0; j <= int'(v_last); j++) begin
            w = (nu[i] * nv[j] + 32768) / 65536;
            addr = i * 16 + j;
            ax += longint'(shadow_x[addr]) * w;
            ay += longint'(shadow_y[addr]) * w;
            az += longint'(shadow_z[addr]) * w;
         end
      end
      pt.x = round_coord(ax);
      pt.y = round_coord(ay);
      pt.z = round_coord(az);
      return pt;
   endfunction

   assign points_pending = expected_points.size();

   initial mismatches = 0;

   always @(posedge clock) begin
      logic [VAL_W-1:0]   knot;
      logic [7:0]         addr;
      surface_point_type  want, got;
      if (reset) begin
         u_last <= 4'd3;
         v_last <= 4'd3;
         u_deg  <= 3'd3;
         v_deg  <= 3'd3;
      end else begin
         // Register writes.
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_U_LAST:   u_last <= csr_data;
               CSR_V_LAST:   v_last <= csr_data;
               CSR_U_DEGREE: u_deg  <= csr_data[2:0];
               CSR_V_DEGREE: v_deg  <= csr_data[2:0];
               default: ;
            endcase
         end
         // Input transactions update the shadow stores or queue a prediction.
         if (req_tvalid && req_tready) begin
            knot = (req_tdata[29:13] > ONE_Q16) ? ONE_Q16 : req_tdata[29:13];
            addr = {req_tdata[3:0], req_tdata[7:4]};
            case (cmd_type'(req_tuser))
               CMD_LOAD_POINT: begin
                  shadow_x[addr] = req_tdata[61:30];
                  shadow_y[addr] = req_tdata[93:62];
                  shadow_z[addr] = req_tdata[125:94];
               end
               CMD_LOAD_U_KNOT: shadow_u_knots[req_tdata[12:8]] = knot;
               CMD_LOAD_V_KNOT: shadow_v_knots[req_tdata[12:8]] = knot;
               CMD_EVAL: expected_points.push_back(
                  surface_point(longint'(req_tdata[142:126]), longint'(req_tdata[159:143])));
               default: ;
            endcase
         end
         // Result transactions against the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got.x = rsp_tdata[31:0];
            got.y = rsp_tdata[63:32];
            got.z = rsp_tdata[95:64];
            if (expected_points.size() == 0) begin
               report_mismatch("surface point with no evaluation outstanding");
            end else begin
               want = expected_points.pop_front();
               if (got.x !== want.x)
                  report_mismatch($sformatf("point_x %0d, want %0d", got.x, want.x));
               if (got.y !== want.y)
                  report_mismatch($sformatf("point_y %0d, want %0d", got.y, want.y));
               if (got.z !== want.z)
                  report_mismatch($sformatf("point_z %0d, want %0d", got.z, want.z));
            end
         end
      end
   end

endmodule

>>> verif/tb_bspline_surface_evaluator.sv
module tb_bspline_surface_evaluator;
   import bse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = 2'd0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = 2'd0;
   logic [3:0]            csr_data = 4'd0;
   int                    mismatches;
   int                    points_pending;
   int                    burst_left = 0;
   int                    stall_mode = 0;
   int                    stall_count = 0;

   bspline_surface_evaluator dut (.*);

   bse_surface_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The result side stalls in stretches: always ready, lightly or heavily stalled.
   always @(posedge clock) begin
      if (stall_count == 0) begin
         stall_mode  <= $urandom_range(0, 2);
         stall_count <= $urandom_range(10, 200);
      end else begin
         stall_count <= stall_count - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // One input transaction; bursts of random length, mostly separated by random gaps.
   task automatic send(input cmd_type cmd, input logic [REQ_DATA_W-1:0] data);
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   function automatic logic [REQ_DATA_W-1:0] pack_item(
         input logic [3:0] us, input logic [3:0] vs, input logic [4:0] ks,
         input logic [16:0] kv, input logic [31:0] x, input logic [31:0] y,
         input logic [31:0] z, input logic [16:0] eu, input logic [16:0] ev);
      return {ev, eu, z, y, x, kv, ks, vs, us};
   endfunction

   task automatic load_point(input int us, input int vs, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
      send(CMD_LOAD_POINT, pack_item(4'(us), 4'(vs), 5'($urandom), 17'($urandom), x, y, z,
                                     17'($urandom), 17'($urandom)));
   endtask

   task automatic load_knot(input cmd_type cmd, input int slot, input logic [16:0] kv);
      send(cmd, pack_item(4'($urandom), 4'($urandom), 5'(slot), kv, $urandom, $urandom,
                          $urandom, 17'($urandom), 17'($urandom)));
   endtask

   task automatic evaluate(input logic [16:0] u, input logic [16:0] v);
      send(CMD_EVAL, pack_item(4'($urandom), 4'($urandom), 5'($urandom), 17'($urandom),
                               $urandom, $urandom, $urandom, u, v));
   endtask

   function automatic logic [31:0] coordinate();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
         default: return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
      endcase
   endfunction

   function automatic logic [16:0] parameter_value();
      case ($urandom_range(0, 9))
         0:       return 17'd0;
         1:       return ONE_Q16;
         2:       return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65535));
      endcase
   endfunction

   // Wait until the block is idle and every point has been returned.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (points_pending != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Clamped interior knot list for one axis: starts at zero, ends at one, sorted.
   task automatic load_sorted_knots(input cmd_type cmd, input int last, input int deg);
      int          count;
      logic [16:0] kv;
      count = last + 1 - deg;
      for (int k = 0; k <= count; k++) begin
         if (k == 0) kv = 17'd0;
         else if (k == count) kv = ONE_Q16;
         else kv = 17'((65536 * k) / count + $urandom_range(0, 2000) - 1000);
         load_knot(cmd, k, kv);
      end
   endtask

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int ul [6] = '{3, 1, 15, 5, 2, 9};
      int vl [6] = '{3, 1, 15, 9, 6, 1};
      int ud [6] = '{3, 1, 7, 2, 7, 0};
      int vd [6] = '{3, 1, 7, 4, 0, 5};
      int evals_left;
      int pick, last, deg;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every store once so that no evaluation reads an unwritten entry.
      for (int a = 0; a < 256; a++) load_point(a / 16, a % 16, coordinate(), coordinate(),
                                               coordinate());
      for (int k = 0; k < 32; k++) begin
         load_knot(CMD_LOAD_U_KNOT, k, 17'($urandom_range(0, 65536)));
         load_knot(CMD_LOAD_V_KNOT, k, 17'($urandom_range(0, 65536)));
      end

      // Directed: reset configuration, extreme parameters and coordinates.
      load_sorted_knots(CMD_LOAD_U_KNOT, 3, 3);
      load_knot(CMD_LOAD_V_KNOT, 0, 17'd0);
      load_knot(CMD_LOAD_V_KNOT, 1, 17'h1FFFF);
      evaluate(17'd0, 17'd0);
      evaluate(ONE_Q16, ONE_Q16);
      evaluate(17'h1FFFF, 17'h1FFFF);
      evaluate(17'h08000, 17'h0C000);
      load_point(0, 0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
      load_point(15, 15, 32'h80000000, 32'h7FFFFFFF, 32'h00000000);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            load_point(i, j, 32'h7FFFFFFF, 32'h80000000, 32'h00008000);
      evaluate(17'h04000, 17'h0E000);
      evaluate(ONE_Q16, 17'd0);
      drain();

      // Random phases, each with its own configuration.
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_U_LAST, 4'(ul[ph]));
         write_reg(CSR_V_LAST, 4'(vl[ph]));
         write_reg(CSR_U_DEGREE, 4'(ud[ph] | ($urandom_range(0, 1) << 3)));
         write_reg(CSR_V_DEGREE, 4'(vd[ph] | ($urandom_range(0, 1) << 3)));
         if (ul[ph] + 1 >= ud[ph]) load_sorted_knots(CMD_LOAD_U_KNOT, ul[ph], ud[ph]);
         if (vl[ph] + 1 >= vd[ph]) load_sorted_knots(CMD_LOAD_V_KNOT, vl[ph], vd[ph]);
         evals_left = (ph == 2) ? 3 : 8;
         while (evals_left > 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
               evaluate(parameter_value(), parameter_value());
               evals_left--;
            end else if (pick < 14) begin
               load_point($urandom_range(0, 15), $urandom_range(0, 15), coordinate(),
                          coordinate(), coordinate());
            end else if (pick < 18) begin
               // Knot noise: mostly outside the list in use, sometimes inside it.
               load_knot(pick[0] ? CMD_LOAD_U_KNOT : CMD_LOAD_V_KNOT,
                         $urandom_range(0, 31), 17'($urandom_range(0, 131071)));
            end else begin
               last = pick[0] ? vl[ph] : ul[ph];
               deg  = pick[0] ? vd[ph] : ud[ph];
               if (last + 1 >= deg)
                  load_sorted_knots(pick[0] ? CMD_LOAD_V_KNOT : CMD_LOAD_U_KNOT, last, deg);
            end
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> bspline_surface_evaluator.f
src/bse_pkg.sv
src/bse_div.sv
src/bspline_surface_evaluator.sv
verif/bse_surface_checker.sv
verif/tb_bspline_surface_evaluator.sv
